>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every edge outside reset
`define NFAEC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define NFAEC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define NFAEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nfaec_pkg.sv
// ---------------------------------------------------------------------------
// nfaec_pkg
// Types, codes and default sizes shared by the epsilon-closure block.
// ---------------------------------------------------------------------------
`default_nettype none

package nfaec_pkg;

  // Field widths fixed by the stream format
  localparam int STATE_W  = 6;
  localparam int LABEL_W  = 8;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // Default table sizes
  localparam int NUM_STATES_DEF    = 64;
  localparam int MAX_EPS_EDGES_DEF = 16;

  // A walk stops emitting after this many members
  localparam int MAX_RESULTS = 63;
  localparam int RES_W       = 6;

  // Epsilon label after reset ('#')
  localparam logic [LABEL_W-1:0] EPS_RESET = 8'd35;

  // Item kinds
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] RES_MEMBER = 2'd0;
  localparam logic [STATUS_W-1:0] RES_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] RES_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] RES_DROP   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;   // capture the accepted input beat
    logic add_exec;    // run an add and post its result
    logic clear_exec;  // empty all lists and post the ack
    logic q_start;     // clear visited map, seed the walk
    logic rd_edge;     // read next successor of the top state
    logic rd_pop;      // read parent level from the walk stack
    logic pop_load;    // restore top from the walk stack
    logic take_edge;   // record a new member, push it
    logic finish;      // post the last beat of a query
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic src_ok;      // start state in range
    logic pos_done;    // top state's list exhausted
    logic depth_one;   // only the start level remains
    logic n_full;      // member limit reached
    logic edge_new;    // successor just read is unvisited
    logic pend_valid;  // a member is held back for is_last
    logic out_free;    // output register can take a beat
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/nfaec_ram.sv
// ---------------------------------------------------------------------------
// nfaec_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module nfaec_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/nfaec_ctrl.sv
// ---------------------------------------------------------------------------
// nfaec_ctrl
// Sequencer for add, clear and depth-first closure walk.
// ---------------------------------------------------------------------------
`default_nettype none

module nfaec_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  nfaec_pkg::stat_t stat,
  output nfaec_pkg::cmd_t  cmd
);
  import nfaec_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_WALK     = 3'd2;
  localparam logic [2:0] S_EDGE     = 3'd3;
  localparam logic [2:0] S_POP      = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.action)
          ACT_ADD: begin
            if (stat.out_free) begin
              cmd.add_exec = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          ACT_CLEAR: begin
            if (stat.out_free) begin
              cmd.clear_exec = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
          ACT_QUERY: begin
            cmd.q_start = 1'b1;
            state_nxt   = stat.src_ok ? S_WALK : S_FINISH;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        if (stat.n_full) begin
          state_nxt = S_FINISH;
        end else if (!stat.pos_done) begin
          cmd.rd_edge = 1'b1;
          state_nxt   = S_EDGE;
        end else if (stat.depth_one) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_pop = 1'b1;
          state_nxt  = S_POP;
        end
      end
      S_EDGE: begin
        // held-back member goes out first, so wait for a free slot
        if (!stat.edge_new) begin
          state_nxt = S_WALK;
        end else if (!stat.pend_valid || stat.out_free) begin
          cmd.take_edge = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_WALK;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nfaec_dp.sv
// ---------------------------------------------------------------------------
// nfaec_dp
// Successor lists, visited map, walk stack and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module nfaec_dp #(
  parameter int NUM_STATES    = nfaec_pkg::NUM_STATES_DEF,
  parameter int MAX_EPS_EDGES = nfaec_pkg::MAX_EPS_EDGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nfaec_pkg::LABEL_W-1:0]     cfg_wdata,
  input  logic [nfaec_pkg::ACTION_W-1:0]    in_action,
  input  logic [nfaec_pkg::LABEL_W-1:0]     in_label,
  input  logic [nfaec_pkg::STATE_W-1:0]     in_src,
  input  logic [nfaec_pkg::STATE_W-1:0]     in_dst,
  input  nfaec_pkg::cmd_t                   cmd,
  output nfaec_pkg::stat_t                  stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nfaec_pkg::STATE_W-1:0]     out_member,
  output logic [nfaec_pkg::STATUS_W-1:0]    out_status,
  output logic                              out_last
);
  import nfaec_pkg::*;

  `include "assert_macros.svh"

  localparam int SIDX_W = $clog2(NUM_STATES);
  localparam int CNT_W  = $clog2(MAX_EPS_EDGES + 1);
  localparam int TAW    = $clog2(NUM_STATES * MAX_EPS_EDGES);
  localparam int TDEPTH = NUM_STATES * MAX_EPS_EDGES;
  localparam int DW     = $clog2(NUM_STATES + 1);
  localparam int SEW    = STATE_W + CNT_W;

  // Configuration and captured item
  logic [LABEL_W-1:0]  eps_r;
  logic [ACTION_W-1:0] action_r;
  logic [LABEL_W-1:0]  label_r;
  logic [STATE_W-1:0]  src_r;
  logic [STATE_W-1:0]  dst_r;

  // List lengths live in a RAM, one valid bit per state marks written ones
  logic [NUM_STATES-1:0] cnt_vld_r;
  logic                  cnt_vld_q;
  logic [NUM_STATES-1:0] visited_r;

  // Walk state: top level lives in registers, parents in the stack RAM
  logic [STATE_W-1:0] top_state_r;
  logic [CNT_W-1:0]   top_pos_r;
  logic [DW-1:0]      depth_r;
  logic [RES_W-1:0]   nmem_r;
  logic               pend_valid_r;
  logic [STATE_W-1:0] pend_state_r;

  // Result register
  logic                out_valid_r;
  logic [STATE_W-1:0]  out_member_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;

  logic [SIDX_W-1:0]   src_idx;
  logic [SIDX_W-1:0]   top_idx;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    cnt_sel;
  logic                cnt_re;
  logic [SIDX_W-1:0]   cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata;
  logic [SIDX_W-1:0]   pop_idx;
  logic                src_ok;
  logic                dst_ok;
  logic                is_eps;
  logic                list_full;
  logic                add_store;
  logic [STATUS_W-1:0] add_code;
  logic                tbl_we;
  logic [TAW-1:0]      tbl_waddr;
  logic [TAW-1:0]      tbl_raddr;
  logic [STATE_W-1:0]  edge_d;
  logic [SIDX_W-1:0]   edge_idx;
  logic                edge_new;
  logic                can_push;
  logic                stk_we;
  logic [SIDX_W-1:0]   stk_waddr;
  logic [SIDX_W-1:0]   stk_raddr;
  logic [SEW-1:0]      stk_wdata;
  logic [SEW-1:0]      stk_q;
  logic                out_free;
  logic                flush_pend;
  logic                emit;

  // Lookups and add decision
  assign src_idx   = SIDX_W'(src_r);
  assign top_idx   = SIDX_W'(top_state_r);
  assign cnt_sel   = cnt_vld_q ? cnt_q : '0;
  assign src_ok    = (32'(src_r) < NUM_STATES);
  assign dst_ok    = (32'(dst_r) < NUM_STATES);
  assign is_eps    = (label_r == eps_r);
  assign list_full = (cnt_sel >= CNT_W'(MAX_EPS_EDGES));
  assign add_store = is_eps && src_ok && dst_ok && !list_full;
  assign add_code  = (!is_eps || !src_ok || !dst_ok) ? RES_DROP :
                     list_full ? RES_FULL : RES_MEMBER;

  // List length RAM: read on item load, on a push and on a pop, so the
  // count of the state being handled is ready in the following cycle
  assign pop_idx   = SIDX_W'(stk_q[SEW-1:CNT_W]);
  assign cnt_re    = cmd.load_item || stk_we || cmd.pop_load;
  assign cnt_raddr = cmd.load_item ? SIDX_W'(in_src) :
                     cmd.pop_load  ? pop_idx : edge_idx;
  assign cnt_wdata = cnt_sel + CNT_W'(1);

  nfaec_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_STATES)
  ) u_cnt (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (src_idx),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  // Successor table addressing: state * MAX_EPS_EDGES + position
  assign tbl_we    = cmd.add_exec && add_store;
  assign tbl_waddr = TAW'(src_idx) * TAW'(MAX_EPS_EDGES) + TAW'(cnt_sel);
  assign tbl_raddr = TAW'(top_idx) * TAW'(MAX_EPS_EDGES) + TAW'(top_pos_r);

  nfaec_ram #(
    .WIDTH (STATE_W),
    .DEPTH (TDEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (dst_r),
    .re    (cmd.rd_edge),
    .raddr (tbl_raddr),
    .rdata (edge_d)
  );

  // Successor just read
  assign edge_idx = SIDX_W'(edge_d);
  assign edge_new = (32'(edge_d) < NUM_STATES) && !visited_r[edge_idx];

  // Walk stack: slot depth-1 saves the current top on a push
  assign can_push  = (depth_r < DW'(NUM_STATES));
  assign stk_we    = cmd.take_edge && can_push;
  assign stk_waddr = SIDX_W'(depth_r - DW'(1));
  assign stk_raddr = SIDX_W'(depth_r - DW'(2));
  assign stk_wdata = {top_state_r, top_pos_r};

  nfaec_ram #(
    .WIDTH (SEW),
    .DEPTH (NUM_STATES)
  ) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (cmd.rd_pop),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  // Output slot
  assign out_free   = !out_valid_r || out_ready;
  assign flush_pend = cmd.take_edge && pend_valid_r;
  assign emit       = cmd.add_exec || cmd.clear_exec || cmd.finish || flush_pend;

  // Status to controller
  always_comb begin
    stat            = '0;
    stat.action     = action_r;
    stat.src_ok     = src_ok;
    stat.pos_done   = (top_pos_r >= cnt_sel);
    stat.depth_one  = (depth_r == DW'(1));
    stat.n_full     = (nmem_r == RES_W'(MAX_RESULTS));
    stat.edge_new   = edge_new;
    stat.pend_valid = pend_valid_r;
    stat.out_free   = out_free;
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r        <= EPS_RESET;
      cnt_vld_r    <= '0;
      visited_r    <= '0;
      depth_r      <= '0;
      nmem_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
      // list length valid bits
      if (cmd.clear_exec) begin
        cnt_vld_r <= '0;
      end else if (tbl_we) begin
        cnt_vld_r[src_idx] <= 1'b1;
      end
      // visited map: only the start state on a new query
      if (cmd.q_start) begin
        visited_r <= NUM_STATES'(src_ok) << src_idx;
      end else if (cmd.take_edge) begin
        visited_r[edge_idx] <= 1'b1;
      end
      // walk depth
      if (cmd.q_start) begin
        depth_r <= DW'(1);
      end else if (stk_we) begin
        depth_r <= depth_r + DW'(1);
      end else if (cmd.rd_pop) begin
        depth_r <= depth_r - DW'(1);
      end else if (cmd.finish) begin
        depth_r <= '0;
      end
      // member count and held-back member
      if (cmd.q_start) begin
        nmem_r       <= '0;
        pend_valid_r <= 1'b0;
      end else if (cmd.take_edge) begin
        nmem_r       <= nmem_r + RES_W'(1);
        pend_valid_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid_r <= 1'b0;
      end
      // output valid
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r <= in_action;
      label_r  <= in_label;
      src_r    <= in_src;
      dst_r    <= in_dst;
    end
    // valid bit travels with the count read
    if (cnt_re) begin
      cnt_vld_q <= cnt_vld_r[cnt_raddr];
    end
    // top of walk
    if (cmd.q_start) begin
      top_state_r <= src_r;
      top_pos_r   <= '0;
    end else if (cmd.rd_edge) begin
      top_pos_r <= top_pos_r + CNT_W'(1);
    end else if (stk_we) begin
      top_state_r <= edge_d;
      top_pos_r   <= '0;
    end else if (cmd.pop_load) begin
      {top_state_r, top_pos_r} <= stk_q;
    end
    if (cmd.take_edge) begin
      pend_state_r <= edge_d;
    end
    // result beat
    if (cmd.add_exec) begin
      out_member_r <= '0;
      out_status_r <= add_code;
      out_last_r   <= 1'b1;
    end else if (cmd.clear_exec) begin
      out_member_r <= '0;
      out_status_r <= RES_MEMBER;
      out_last_r   <= 1'b1;
    end else if (flush_pend) begin
      out_member_r <= pend_state_r;
      out_status_r <= RES_MEMBER;
      out_last_r   <= 1'b0;
    end else if (cmd.finish) begin
      out_member_r <= pend_valid_r ? pend_state_r : '0;
      out_status_r <= pend_valid_r ? RES_MEMBER : RES_EMPTY;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_member = out_member_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // Checks
  `NFAEC_ASSERT_ALWAYS(a_depth_bound, depth_r <= DW'(NUM_STATES), "walk stack overflow")
  `NFAEC_ASSERT_IMPLY(a_emit_free, emit, out_free, "result overwrites a waiting beat")
  `NFAEC_ASSERT_IMPLY(a_take_new, cmd.take_edge, edge_new, "visited state taken again")
  `NFAEC_ASSERT_NEXT(a_take_pend, cmd.take_edge, pend_valid_r, "member not held back")

endmodule

`default_nettype wire

>>> rtl/nfa_epsilon_closure_top.sv
// ---------------------------------------------------------------------------
// nfa_epsilon_closure_top
// Epsilon-closure engine over stored per-state epsilon successor lists.
// ---------------------------------------------------------------------------
// Items are handled one at a time. An add or clear posts its result beat from
// dispatch into the output register, and the next input is taken back in
// idle. A query runs dispatch, then for each stored edge read from a reached
// state a table read and a visited check, for each backtrack a stack read
// and a top restore, then the final check of the start level, the last beat
// and the return to idle, since each list entry comes out of the successor
// table RAM through its registered read port and each backtrack reads the
// walk stack RAM. The list length of a new top state is read from the count
// RAM alongside its push or pop. Members leave one beat behind the walk so
// that the final one can carry tlast. No clearing pass after reset: list
// lengths sit in a RAM beside one valid flip-flop per state, cleared at
// reset and by a clear item, and the visited map sits in flip-flops. A
// stalled output holds the walk; the next input is taken once the previous
// item has posted its last beat into the output register.
`default_nettype none

module nfa_epsilon_closure_top #(
  parameter int NUM_STATES    = nfaec_pkg::NUM_STATES_DEF,
  parameter int MAX_EPS_EDGES = nfaec_pkg::MAX_EPS_EDGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: epsilon label byte
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // label[7:0], source_state[13:8], dest_state[19:14]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // member_state[5:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast   // is_last
);
  import nfaec_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic [STATE_W-1:0] member;

  nfaec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nfaec_dp #(
    .NUM_STATES    (NUM_STATES),
    .MAX_EPS_EDGES (MAX_EPS_EDGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_action  (in_tuser),
    .in_label   (in_tdata[7:0]),
    .in_src     (in_tdata[13:8]),
    .in_dst     (in_tdata[19:14]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_member (member),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, member};

endmodule

`default_nettype wire

>>> tb/tb_nfa_epsilon_closure_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nfa_epsilon_closure_top
// Self-checking bench for the epsilon-closure engine. A queue-fed driver
// sends add, query and clear beats with random gaps. A monitor predicts the
// closure results from its own copy of the successor lists and checks every
// result beat in order. The run covers several epsilon labels, the list-full
// case, cycles and self loops, and a 63-member chain walk.
// ---------------------------------------------------------------------------

module tb_nfa_epsilon_closure_top;
  import nfaec_pkg::*;

  localparam int NUM_ST    = NUM_STATES_DEF;
  localparam int MAX_EDGES = MAX_EPS_EDGES_DEF;
  localparam int RAND_PER_PHASE = 80;
  localparam int SETTLE_CYCLES  = 20;
  localparam int END_CYCLES     = 100;

  // Unused action code, the block ignores it
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LABEL_W-1:0]  label;
    logic [STATE_W-1:0]  src;
    logic [STATE_W-1:0]  dst;
  } nfa_item_t;

  typedef struct packed {
    logic [STATE_W-1:0]  member;
    logic [STATUS_W-1:0] status;
    logic                is_last;
  } closure_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = 24'd0;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  nfa_epsilon_closure_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Shadow copy of the block's lists and label
  logic [LABEL_W-1:0] eps_label = EPS_RESET;
  logic [STATE_W-1:0] succ_list [NUM_ST][MAX_EDGES];
  int                 succ_len  [NUM_ST];

  nfa_item_t     pending_items [$];
  closure_beat_t closure_q [$];
  int            fail_count = 0;
  bit            calm = 1'b0;
  logic          in_accepted = 1'b0;
  int            in_gap = 0;
  int            out_gap = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_ST; i++) succ_len[i] = 0;
  end

  function automatic nfa_item_t mk_item(input logic [ACTION_W-1:0] action,
                                        input int label, input int src, input int dst);
    nfa_item_t it;
    it.action = action;
    it.label  = LABEL_W'(label);
    it.src    = STATE_W'(src);
    it.dst    = STATE_W'(dst);
    return it;
  endfunction

  function automatic void queue_beat(input int member, input logic [STATUS_W-1:0] status,
                                     input logic is_last);
    closure_beat_t b;
    b.member  = STATE_W'(member);
    b.status  = status;
    b.is_last = is_last;
    closure_q.push_back(b);
  endfunction

  // Work out the result beats of one accepted item
  task automatic predict_closure(input nfa_item_t it);
    int stk_state [NUM_ST];
    int stk_pos [NUM_ST];
    bit seen [NUM_ST];
    int depth;
    int top;
    int s;
    int p;
    int d;
    int n;
    closure_beat_t tail;
    case (it.action)
      ACT_ADD: begin
        if (it.label != eps_label) begin
          queue_beat(0, RES_DROP, 1'b1);
        end else if (succ_len[it.src] >= MAX_EDGES) begin
          queue_beat(0, RES_FULL, 1'b1);
        end else begin
          succ_list[it.src][succ_len[it.src]] = it.dst;
          succ_len[it.src]++;
          queue_beat(0, RES_MEMBER, 1'b1);
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < NUM_ST; i++) succ_len[i] = 0;
        queue_beat(0, RES_MEMBER, 1'b1);
      end
      ACT_QUERY: begin
        for (int i = 0; i < NUM_ST; i++) seen[i] = 1'b0;
        seen[it.src] = 1'b1;
        stk_state[0] = it.src;
        stk_pos[0] = 0;
        depth = 1;
        n = 0;
        // depth-first walk, start state never emitted
        while (depth > 0 && n < MAX_RESULTS) begin
          top = depth - 1;
          s = stk_state[top];
          p = stk_pos[top];
          if (p >= succ_len[s]) begin
            depth--;
          end else begin
            stk_pos[top] = p + 1;
            d = succ_list[s][p];
            if (!seen[d]) begin
              seen[d] = 1'b1;
              queue_beat(d, RES_MEMBER, 1'b0);
              n++;
              if (depth < NUM_ST) begin
                stk_state[depth] = d;
                stk_pos[depth] = 0;
                depth++;
              end
            end
          end
        end
        if (n == 0) begin
          queue_beat(0, RES_EMPTY, 1'b1);
        end else begin
          tail = closure_q.pop_back();
          tail.is_last = 1'b1;
          closure_q.push_back(tail);
        end
      end
      default: ;
    endcase
  endtask

  // Random beat: mostly epsilon adds and queries around a small hot set
  function automatic nfa_item_t rand_item(input logic [LABEL_W-1:0] eps,
                                          input int base, input int span);
    nfa_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.action = ACT_ADD;
    it.label  = LABEL_W'($urandom_range(0, 255));
    it.src    = STATE_W'($urandom_range(0, NUM_ST - 1));
    it.dst    = STATE_W'($urandom_range(0, NUM_ST - 1));
    if (pick < 63) begin
      if ($urandom_range(0, 9) < 8) begin
        it.label = eps;
        it.src = STATE_W'((base + $urandom_range(0, span - 1)) % NUM_ST);
        if ($urandom_range(0, 3) != 0)
          it.dst = STATE_W'((base + $urandom_range(0, span - 1)) % NUM_ST);
      end
    end else if (pick < 93) begin
      it.action = ACT_QUERY;
      if ($urandom_range(0, 4) != 0)
        it.src = STATE_W'((base + $urandom_range(0, span - 1)) % NUM_ST);
    end else if (pick < 96) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  task automatic add_random(input logic [LABEL_W-1:0] eps, input int span);
    int base;
    base = $urandom_range(0, NUM_ST - 1);
    for (int i = 0; i < RAND_PER_PHASE; i++)
      pending_items.push_back(rand_item(eps, base, span));
  endtask

  // Block is idle: all beats sent, nothing expected, short settle
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || in_tvalid || closure_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_eps(input logic [LABEL_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    eps_label = value;
  endtask

  // Input driver: next beat at the falling edge once the last one is taken
  always @(negedge clk) begin
    nfa_item_t next_item;
    logic      next_valid;
    next_valid = 1'b0;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (in_tvalid && !in_accepted) begin
      next_valid = 1'b1;
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
    end else if (pending_items.size() > 0) begin
      next_item = pending_items.pop_front();
      in_tdata <= {4'b0, next_item.dst, next_item.src, next_item.label};
      in_tuser <= next_item.action;
      next_valid = 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) in_gap <= $urandom_range(1, 6);
    end
    in_tvalid <= next_valid;
  end

  // Result side backpressure in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 6);
    end
  end

  // Monitor: check result beats, predict accepted input beats
  always @(posedge clk) begin
    closure_beat_t want;
    nfa_item_t     got_item;
    if (rst_n) begin
      in_accepted <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (closure_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got tdata %h tuser %0d tlast %0d",
                   $time, out_tdata, out_tuser, out_tlast);
          fail_count++;
        end else begin
          want = closure_q.pop_front();
          if (out_tdata != {2'b0, want.member} || out_tuser != want.status ||
              out_tlast != want.is_last) begin
            $display("%0t: mismatch: expected member %0d status %0d last %0d, got tdata %h status %0d last %0d",
                     $time, want.member, want.status, want.is_last,
                     out_tdata, out_tuser, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        got_item.action = in_tuser;
        got_item.label  = in_tdata[7:0];
        got_item.src    = in_tdata[13:8];
        got_item.dst    = in_tdata[19:14];
        predict_closure(got_item);
      end
    end else begin
      in_accepted <= 1'b0;
    end
  end

  // Stimulus sequence
  initial begin
    logic [LABEL_W-1:0] chain_eps;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset label, list fill to full, drops, cycles, self loop
    pending_items.push_back(mk_item(ACT_ADD, EPS_RESET, 2, 63));
    pending_items.push_back(mk_item(ACT_ADD, EPS_RESET, 2, 0));
    pending_items.push_back(mk_item(ACT_ADD, EPS_RESET, 2, 2));
    pending_items.push_back(mk_item(ACT_ADD, EPS_RESET, 2, 2));
    for (int d = 3; d < 15; d++) pending_items.push_back(mk_item(ACT_ADD, EPS_RESET, 2, d));
    pending_items.push_back(mk_item(ACT_ADD, EPS_RESET, 2, 5));
    pending_items.push_back(mk_item(ACT_ADD, 255, 63, 63));
    pending_items.push_back(mk_item(ACT_ADD, 0, 0, 0));
    pending_items.push_back(mk_item(ACT_ADD, EPS_RESET, 63, 2));
    pending_items.push_back(mk_item(ACT_QUERY, 0, 2, 0));
    pending_items.push_back(mk_item(ACT_QUERY, 255, 1, 63));
    pending_items.push_back(mk_item(ACT_NONE, 255, 63, 63));
    pending_items.push_back(mk_item(ACT_CLEAR, 0, 0, 0));
    pending_items.push_back(mk_item(ACT_QUERY, 0, 2, 0));
    wait_idle();

    // Random with the lowest label
    write_eps(8'd0);
    add_random(8'd0, 10);
    wait_idle();

    // Random with the highest label, few sources so lists fill up
    write_eps(8'd255);
    add_random(8'd255, 3);
    wait_idle();

    // Ring of all states: walks reach the member limit
    chain_eps = LABEL_W'($urandom_range(1, 254));
    write_eps(chain_eps);
    pending_items.push_back(mk_item(ACT_CLEAR, 0, 0, 0));
    for (int s = 0; s < NUM_ST - 1; s++)
      pending_items.push_back(mk_item(ACT_ADD, chain_eps, s, s + 1));
    pending_items.push_back(mk_item(ACT_ADD, chain_eps, NUM_ST - 1, 0));
    pending_items.push_back(mk_item(ACT_QUERY, 0, 0, 0));
    pending_items.push_back(mk_item(ACT_QUERY, 0, NUM_ST - 1, 0));
    pending_items.push_back(mk_item(ACT_QUERY, 0, 31, 0));
    wait_idle();

    // Back to the reset label, no idling on either side
    write_eps(EPS_RESET);
    calm = 1'b1;
    add_random(EPS_RESET, 6);
    wait_idle();

    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && closure_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
